@@ design/btwr_pkg.sv @@
// Package for the bitmap text wrap renderer: field widths, codes, defaults
// and the command/status structs shared by the controller and datapath.
// No dependencies.
package btwr_pkg;

	// Font geometry defaults (top-level parameters take these)
	localparam int DEF_GLYPH_HEIGHT = 16;
	localparam int DEF_FIRST_CODE   = 32;
	localparam int DEF_LAST_CODE    = 126;
	localparam int GLYPH_WIDTH      = 8;

	// Input item kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_CHAR  = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'd32;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR      = 3'd5;

	// Configuration reset values
	localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd1024;
	localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;
	localparam logic [13:0] RST_ROW_PITCH     = 14'd1024;
	localparam logic [12:0] RST_WRAP_WIDTH    = 13'd1024;
	localparam logic [31:0] RST_FG_COLOR      = 32'hFFFF_FFFF;
	localparam logic [31:0] RST_BG_COLOR      = 32'h0000_0000;

	localparam logic [15:0] LINES_MAX = 16'hFFFF;

	// Controller to datapath
	typedef struct packed {
		logic load_glyph;
		logic start_text;
		logic new_line;
		logic begin_char;
		logic issue_row;
	} btwr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic advance;
		logic row_last;
	} btwr_sts_t;

endpackage

@@ design/btwr_if.sv @@
// Channel interfaces of the text renderer: input items, row results and
// configuration writes, each with valid/ready. Depends on btwr_pkg.
interface btwr_item_if import btwr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic        [1:0]  kind;
	logic        [6:0]  glyph_index;
	logic        [3:0]  glyph_row;
	logic        [7:0]  row_bits;
	logic signed [12:0] pos_x;
	logic signed [12:0] pos_y;
	logic        [7:0]  char_code;

	modport source (output valid, kind, glyph_index, glyph_row, row_bits, pos_x, pos_y,
		char_code, input ready);
	modport sink (input valid, kind, glyph_index, glyph_row, row_bits, pos_x, pos_y,
		char_code, output ready);
endinterface

interface btwr_result_if import btwr_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] pixel_addr;
	logic [7:0]  write_mask;
	logic [7:0]  fg_select;
	logic [15:0] line_count;
	logic        last_row;

	modport source (output valid, pixel_addr, write_mask, fg_select, line_count, last_row,
		input ready);
	modport sink (input valid, pixel_addr, write_mask, fg_select, line_count, last_row,
		output ready);
endinterface

interface btwr_cfg_if import btwr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/btwr_ctrl.sv @@
// Controller state machine of the text renderer: accepts items, decodes
// their kind and sequences the glyph row issue. Depends on btwr_pkg.
module btwr_ctrl import btwr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] kind,
	input  logic [7:0] char_code,
	input  btwr_sts_t  sts,
	output btwr_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_ROWS = 1'b1;

	logic state_q;
	logic state_d;
	logic take;

	assign item_ready = (state_q == ST_IDLE);
	assign take       = item_valid && item_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (kind)
						KIND_LOAD:  cmd.load_glyph = 1'b1;
						KIND_START: cmd.start_text = 1'b1;
						KIND_CHAR: begin
							if (char_code == NEWLINE_CODE) begin
								cmd.new_line = 1'b1;
							end else begin
								cmd.begin_char = 1'b1;
								state_d        = ST_ROWS;
							end
						end
						default: ;
					endcase
				end
			end
			ST_ROWS: begin
				// issue one row per cycle the pipeline moves
				cmd.issue_row = sts.advance;
				if (sts.advance && sts.row_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/btwr_dp.sv @@
// Datapath of the text renderer: configuration registers, cursor state,
// glyph store memory and the row pipeline to the result register.
// Depends on btwr_pkg; driven by btwr_ctrl commands.
module btwr_dp import btwr_pkg::*; #(
	parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT,
	parameter int FIRST_CODE   = DEF_FIRST_CODE,
	parameter int LAST_CODE    = DEF_LAST_CODE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  btwr_cmd_t            cmd,
	output btwr_sts_t            sts,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [6:0]           glyph_index,
	input  logic [3:0]           glyph_row,
	input  logic [7:0]           row_bits,
	input  logic signed [12:0]   pos_x,
	input  logic signed [12:0]   pos_y,
	input  logic [7:0]           char_code,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [31:0]          pixel_addr,
	output logic [7:0]           write_mask,
	output logic [7:0]           fg_select,
	output logic [15:0]          line_count,
	output logic                 last_row
);

	localparam int NUM_GLYPHS = LAST_CODE - FIRST_CODE + 1;
	localparam int DEPTH      = NUM_GLYPHS * GLYPH_HEIGHT;
	localparam int AW         = $clog2(DEPTH);
	localparam int RW         = $clog2(GLYPH_HEIGHT);

	// Configuration registers
	logic [12:0] screen_width_q;
	logic [12:0] screen_height_q;
	logic [13:0] row_pitch_q;
	logic [12:0] wrap_width_q;
	logic [31:0] bg_color_q;

	// Cursor state
	logic [15:0] left_margin_q;
	logic [15:0] cursor_col_q;
	logic [15:0] cursor_row_q;
	logic [15:0] lines_used_q;

	// Current character
	logic [AW-1:0] char_base_q;
	logic [15:0]   char_x_q;
	logic [15:0]   char_y_q;
	logic [15:0]   char_lines_q;
	logic [RW-1:0] row_q;

	logic [7:0] mem [DEPTH];

	// Pipeline
	logic               advance;
	logic               v_s1, v_s2;
	logic [7:0]         bits_s1;
	logic signed [16:0] py_s1;
	logic [15:0]        x_s1, x_s2;
	logic [15:0]        lines_s1, lines_s2;
	logic               last_s1, last_s2;
	logic signed [31:0] prod_s2;
	logic [7:0]         wm_s2, sel_s2;

	// Cursor arithmetic
	logic [15:0]        lines_inc;
	logic [15:0]        row_next;
	logic signed [17:0] wrap_lhs, wrap_rhs;
	logic               wrap;
	logic [15:0]        x_d, y_d, lines_d;
	logic               code_ok;
	logic [7:0]         glyph_sel;
	logic               load_ok;
	logic [AW-1:0]      waddr, raddr;

	assign lines_inc = (lines_used_q == LINES_MAX) ? lines_used_q : lines_used_q + 16'd1;
	assign row_next  = cursor_row_q + 16'(GLYPH_HEIGHT);

	assign wrap_lhs = $signed({{2{cursor_col_q[15]}}, cursor_col_q}) + 18'sd8;
	assign wrap_rhs = $signed({{2{left_margin_q[15]}}, left_margin_q})
		+ $signed({5'b0, wrap_width_q});
	assign wrap     = wrap_lhs > wrap_rhs;

	assign x_d     = wrap ? left_margin_q : cursor_col_q;
	assign y_d     = wrap ? row_next : cursor_row_q;
	assign lines_d = wrap ? lines_inc : lines_used_q;

	assign code_ok   = (char_code >= 8'(FIRST_CODE)) && ({1'b0, char_code} <= 9'(LAST_CODE));
	assign glyph_sel = code_ok ? (char_code - 8'(FIRST_CODE)) : (SPACE_CODE - 8'(FIRST_CODE));

	assign load_ok = ({2'b0, glyph_index} < 9'(NUM_GLYPHS)) && ({2'b0, glyph_row} < 6'(GLYPH_HEIGHT));
	assign waddr   = AW'(32'(glyph_index) * 32'(GLYPH_HEIGHT) + 32'(glyph_row));
	assign raddr   = char_base_q + AW'(row_q);

	assign advance      = !res_valid || res_ready;
	assign sts.advance  = advance;
	assign sts.row_last = (row_q == RW'(GLYPH_HEIGHT - 1));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
			row_pitch_q     <= RST_ROW_PITCH;
			wrap_width_q    <= RST_WRAP_WIDTH;
			bg_color_q      <= RST_BG_COLOR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[12:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[12:0];
				REG_ROW_PITCH:     row_pitch_q     <= cfg_data[13:0];
				REG_WRAP_WIDTH:    wrap_width_q    <= cfg_data[12:0];
				// fg_color is not stored here; nothing here depends on it
				REG_FG_COLOR: ;
				REG_BG_COLOR:      bg_color_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Cursor and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_margin_q <= '0;
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			lines_used_q  <= 16'd1;
			row_q         <= '0;
		end else begin
			if (cmd.start_text) begin
				left_margin_q <= {{3{pos_x[12]}}, pos_x};
				cursor_col_q  <= {{3{pos_x[12]}}, pos_x};
				cursor_row_q  <= {{3{pos_y[12]}}, pos_y};
				lines_used_q  <= 16'd1;
			end else if (cmd.new_line) begin
				cursor_col_q <= left_margin_q;
				cursor_row_q <= row_next;
				lines_used_q <= lines_inc;
			end else if (cmd.begin_char) begin
				cursor_col_q <= x_d + 16'(GLYPH_WIDTH);
				cursor_row_q <= y_d;
				lines_used_q <= lines_d;
			end
			if (cmd.begin_char) begin
				row_q <= '0;
			end else if (cmd.issue_row) begin
				row_q <= row_q + RW'(1);
			end
		end
	end

	// Character snapshot for the row sequence
	always_ff @(posedge clk) begin
		if (cmd.begin_char) begin
			char_base_q  <= AW'(32'(glyph_sel) * 32'(GLYPH_HEIGHT));
			char_x_q     <= x_d;
			char_y_q     <= y_d;
			char_lines_q <= lines_d;
		end
	end

	// Glyph store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_glyph && load_ok) begin
			mem[waddr] <= row_bits;
		end
		if (advance) begin
			bits_s1 <= mem[raddr];
		end
	end

	// Valid bits of the row pipeline; every stage moves together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			res_valid <= 1'b0;
		end else if (advance) begin
			v_s1      <= cmd.issue_row;
			v_s2      <= v_s1;
			res_valid <= v_s2;
		end
	end

	// Stage 1: row coordinates alongside the memory read
	always_ff @(posedge clk) begin
		if (advance) begin
			py_s1    <= $signed({char_y_q[15], char_y_q}) + $signed({{(17-RW){1'b0}}, row_q});
			x_s1     <= char_x_q;
			lines_s1 <= char_lines_q;
			last_s1  <= sts.row_last;
		end
	end

	// Stage 2: row product and clipped masks
	logic [7:0]         sel_c, vis_c;
	logic               row_vis;
	logic signed [16:0] px [GLYPH_WIDTH];

	assign row_vis = !py_s1[16] && (py_s1[15:0] < {3'b0, screen_height_q});

	always_comb begin
		for (int i = 0; i < GLYPH_WIDTH; i++) begin
			px[i]    = $signed({x_s1[15], x_s1}) + 17'(i);
			sel_c[i] = bits_s1[GLYPH_WIDTH - 1 - i];
			vis_c[i] = row_vis && !px[i][16] && (px[i][15:0] < {3'b0, screen_width_q});
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2  <= 32'(py_s1) * $signed({18'b0, row_pitch_q});
			sel_s2   <= sel_c;
			wm_s2    <= vis_c & ((bg_color_q != 32'd0) ? 8'hFF : sel_c);
			x_s2     <= x_s1;
			lines_s2 <= lines_s1;
			last_s2  <= last_s1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_addr <= 32'(prod_s2) + {{16{x_s2[15]}}, x_s2};
			write_mask <= wm_s2;
			fg_select  <= sel_s2;
			line_count <= lines_s2;
			last_row   <= last_s2;
		end
	end

endmodule

@@ design/bitmap_text_wrap_renderer_core.sv @@
// Bitmap text wrap renderer: 8-pixel wide glyphs, one row result per glyph row.
// A character item is accepted while idle, then issues GLYPH_HEIGHT rows, one a cycle
// while the result side takes them; each row passes stage 1, stage 2 and the result register.
// No item is taken while rows issue; load, start and newline items keep the controller idle.
// Reset (arst_n low) restores register defaults, cursor origin and a line count of one;
// the glyph store is not cleared and must be loaded before use.
module bitmap_text_wrap_renderer_core import btwr_pkg::*; #(
	parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT,
	parameter int FIRST_CODE   = DEF_FIRST_CODE,
	parameter int LAST_CODE    = DEF_LAST_CODE
) (
	input  logic          clk,
	input  logic          arst_n,
	btwr_item_if.sink     item,
	btwr_result_if.source result,
	btwr_cfg_if.sink      cfg
);

	btwr_cmd_t cmd;
	btwr_sts_t sts;

	assign cfg.ready = 1'b1;

	btwr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.kind       (item.kind),
		.char_code  (item.char_code),
		.sts        (sts),
		.cmd        (cmd)
	);

	btwr_dp #(
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.FIRST_CODE   (FIRST_CODE),
		.LAST_CODE    (LAST_CODE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.glyph_index (item.glyph_index),
		.glyph_row   (item.glyph_row),
		.row_bits    (item.row_bits),
		.pos_x       (item.pos_x),
		.pos_y       (item.pos_y),
		.char_code   (item.char_code),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.pixel_addr  (result.pixel_addr),
		.write_mask  (result.write_mask),
		.fg_select   (result.fg_select),
		.line_count  (result.line_count),
		.last_row    (result.last_row)
	);

endmodule
